FILE: hdl/ehm_pkg.sv
// Shared types, constants and widths for the envelope histogram mask block.
package ehm_pkg;

   localparam int BINS        = 256;
   localparam int TABLE_DEPTH = 256;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam int BIN_MAX     = ((BINS < TABLE_DEPTH) ? BINS : TABLE_DEPTH) - 1;

   localparam int COUNT_W = 13;
   localparam int VALUE_W = 32;
   localparam int DEV_W   = 31;
   localparam int MAG_W   = 33;           // magnitude of a 33-bit difference
   localparam int NUM_W   = MAG_W + 16;   // dividend after the Q16 shift
   localparam int DIV_STEPS = NUM_W;      // one quotient bit per stage

   localparam logic signed [15:0] TENTH_Q16 = 16'sd6554;

   localparam int CSR_AW = 2;
   typedef enum logic [CSR_AW-1:0] {
      CSR_QUERY_LENGTH = 2'd0,
      CSR_BIN_SCALE    = 2'd1,
      CSR_VALUE_MIN    = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   typedef enum logic {
      CMD_LOAD     = 1'b0,
      CMD_CLASSIFY = 1'b1
   } cmd_type;

   // Sideband that travels with every beat through the pipeline.
   typedef struct packed {
      logic                valid;
      cmd_type             cmd;
      logic [TABLE_AW-1:0] index;
      logic [COUNT_W-1:0]  count;
      logic                fault;
   } side_type;

   typedef struct packed {
      side_type         side;
      logic [DEV_W-1:0] dev;
      logic             neg_u;
      logic             neg_l;
      logic [NUM_W-1:0] num_u;
      logic [NUM_W-1:0] num_l;
      logic [DEV_W-1:0] rem_u;
      logic [DEV_W-1:0] rem_l;
      logic [NUM_W-1:0] quo_u;
      logic [NUM_W-1:0] quo_l;
   } div_type;

endpackage

FILE: hdl/ehm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ehm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/ehm_div.sv
// Restoring divider pipeline: one quotient bit of both values per stage.
module ehm_div (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  ehm_pkg::div_type div_in,
   output ehm_pkg::div_type div_out
);
   import ehm_pkg::*;

   div_type stage_ff [DIV_STEPS];
   div_type stage_in [DIV_STEPS];

   function automatic logic [DEV_W:0] trial(input logic [DEV_W-1:0] rem, input logic bit_in);
      trial = {rem, bit_in};
   endfunction

   always_comb begin
      div_type           cur;
      div_type           nxt;
      logic [DEV_W:0]    tu;
      logic [DEV_W:0]    tl;
      logic              geu;
      logic              gel;
      for (int k = 0; k < DIV_STEPS; k++) begin
         cur = (k == 0) ? div_in : stage_ff[k-1];
         nxt = cur;
         tu  = trial(cur.rem_u, cur.num_u[NUM_W-1]);
         tl  = trial(cur.rem_l, cur.num_l[NUM_W-1]);
         geu = (tu >= {1'b0, cur.dev});
         gel = (tl >= {1'b0, cur.dev});
         nxt.rem_u = geu ? DEV_W'(tu - {1'b0, cur.dev}) : tu[DEV_W-1:0];
         nxt.rem_l = gel ? DEV_W'(tl - {1'b0, cur.dev}) : tl[DEV_W-1:0];
         nxt.num_u = {cur.num_u[NUM_W-2:0], 1'b0};
         nxt.num_l = {cur.num_l[NUM_W-2:0], 1'b0};
         nxt.quo_u = {cur.quo_u[NUM_W-2:0], geu};
         nxt.quo_l = {cur.quo_l[NUM_W-2:0], gel};
         stage_in[k] = nxt;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
         if (reset) begin
            stage_ff[k].side.valid <= 1'b0;
         end else if (advance) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign div_out = stage_ff[DIV_STEPS-1];

endmodule

FILE: hdl/ehm_quant.sv
// Sign, offset, saturate, scale and clamp both quotients into bin numbers.
module ehm_quant (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [ehm_pkg::DEV_W-1:0]         bin_scale,
   input  logic signed [ehm_pkg::VALUE_W-1:0] value_min,
   input  ehm_pkg::div_type                  div_in,
   output ehm_pkg::side_type                 side_out,
   output logic [ehm_pkg::TABLE_AW-1:0]      bin_u,
   output logic [ehm_pkg::TABLE_AW-1:0]      bin_l
);
   import ehm_pkg::*;

   localparam int ZW = NUM_W + 2;

   side_type                   s1_ff, s2_ff, s3_ff, s4_ff;
   logic signed [VALUE_W-1:0]  zu_ff, zl_ff, zu_in, zl_in;
   logic [VALUE_W-1:0]         du_ff, dl_ff, du_in, dl_in;
   logic                       pu_ff, pl_ff, pu_in, pl_in;
   logic                       pu3_ff, pl3_ff;
   logic [VALUE_W+DEV_W-1:0]   mu_ff, ml_ff;
   logic [TABLE_AW-1:0]        bu_ff, bl_ff, bu_in, bl_in;

   function automatic logic signed [VALUE_W-1:0] norm(input logic neg,
         input logic [NUM_W-1:0] q, input logic signed [15:0] off);
      logic signed [ZW-1:0] z;
      z = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
      z = z + ZW'(off);
      if (z > ZW'(64'sh7FFFFFFF)) norm = 32'sh7FFFFFFF;
      else if (z < -ZW'(64'sh80000000)) norm = 32'sh80000000;
      else norm = z[VALUE_W-1:0];
   endfunction

   function automatic logic [TABLE_AW-1:0] clamp(input logic pos,
         input logic [VALUE_W+DEV_W-1:0] m);
      logic [DEV_W-1:0] b;
      b = m[VALUE_W+DEV_W-1:VALUE_W];
      if (!pos) clamp = '0;
      else if (b > DEV_W'(BIN_MAX)) clamp = TABLE_AW'(BIN_MAX);
      else clamp = b[TABLE_AW-1:0];
   endfunction

   always_comb begin
      logic signed [VALUE_W:0] du;
      logic signed [VALUE_W:0] dl;
      zu_in = norm(div_in.neg_u, div_in.quo_u, TENTH_Q16);
      zl_in = norm(div_in.neg_l, div_in.quo_l, -TENTH_Q16);
      du = {zu_ff[VALUE_W-1], zu_ff} - {value_min[VALUE_W-1], value_min};
      dl = {zl_ff[VALUE_W-1], zl_ff} - {value_min[VALUE_W-1], value_min};
      pu_in = (du > 0);
      pl_in = (dl > 0);
      du_in = du[VALUE_W-1:0];
      dl_in = dl[VALUE_W-1:0];
      bu_in = clamp(pu3_ff, mu_ff);
      bl_in = clamp(pl3_ff, ml_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ff <= div_in.side;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
         s4_ff <= s3_ff;
      end
      if (advance) begin
         zu_ff  <= zu_in;
         zl_ff  <= zl_in;
         du_ff  <= du_in;
         dl_ff  <= dl_in;
         pu_ff  <= pu_in;
         pl_ff  <= pl_in;
         mu_ff  <= du_ff * bin_scale;
         ml_ff  <= dl_ff * bin_scale;
         pu3_ff <= pu_ff;
         pl3_ff <= pl_ff;
         bu_ff  <= bu_in;
         bl_ff  <= bl_in;
      end
   end

   assign side_out = s4_ff;
   assign bin_u    = bu_ff;
   assign bin_l    = bl_ff;

endmodule

FILE: hdl/envelope_histogram_mask.sv
// Top level of the envelope histogram mask: pipeline control, table, compare.
// Pipeline from an accepted req beat to its rsp beat: input stage,
// difference stage, 49 divider stages, 4 quantizer stages, table read, output.
// Throughput: one beat per cycle; the whole pipeline holds only while a rsp
// beat waits at the output register.
// Reset clears all valid bits and loads the configuration reset values; the
// bin table is not cleared and must be loaded before it is read.
module envelope_histogram_mask (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [151:0] req_tdata,  // bin_index[7:0], bin_count[20:8], upper_value[52:21],
                                    // lower_value[84:53], window_mean[116:85],
                                    // window_deviation[147:117], zero pad[151:148]
   input  logic         req_tuser,  // command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,  // mask_bit[0], divide_fault[1], zero pad[7:2]
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import ehm_pkg::*;

   // Configuration registers
   logic [COUNT_W-1:0]        query_length_ff;
   logic [DEV_W-1:0]          bin_scale_ff;
   logic signed [VALUE_W-1:0] value_min_ff;

   logic rsp_tvalid_ff;
   logic mask_ff, fault_ff;
   logic mask_in;

   // Global pipeline advance: move every stage unless a finished beat is stuck.
   logic advance;
   assign advance    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         query_length_ff <= COUNT_W'(128);
         bin_scale_ff    <= DEV_W'(65536);
         value_min_ff    <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_QUERY_LENGTH: query_length_ff <= csr_data[COUNT_W-1:0];
            CSR_BIN_SCALE:    bin_scale_ff    <= csr_data[DEV_W-1:0];
            CSR_VALUE_MIN:    value_min_ff    <= csr_data;
            default:          ;
         endcase
      end
   end

   // Stage 1: capture the beat.
   side_type                  in_side_ff;
   logic signed [VALUE_W-1:0] up_ff, lo_ff, mean_ff;
   logic [DEV_W-1:0]          dev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_side_ff.valid <= 1'b0;
      end else if (advance) begin
         in_side_ff.valid <= req_tvalid;
      end
      if (advance) begin
         in_side_ff.cmd   <= cmd_type'(req_tuser);
         in_side_ff.index <= req_tdata[7:0];
         in_side_ff.count <= req_tdata[20:8];
         in_side_ff.fault <= 1'b0;
         up_ff            <= req_tdata[52:21];
         lo_ff            <= req_tdata[84:53];
         mean_ff          <= req_tdata[116:85];
         dev_ff           <= req_tdata[147:117];
      end
   end

   // Stage 2: take the difference to the mean, split into sign and magnitude, flag a zero deviation as a fault.
   div_type div_in;
   div_type div_out;

   always_comb begin
      logic signed [MAG_W-1:0] nu;
      logic signed [MAG_W-1:0] nl;
      nu = {up_ff[VALUE_W-1], up_ff} - {mean_ff[VALUE_W-1], mean_ff};
      nl = {lo_ff[VALUE_W-1], lo_ff} - {mean_ff[VALUE_W-1], mean_ff};
      div_in            = '0;
      div_in.side       = in_side_ff;
      div_in.side.fault = (dev_ff == '0);
      div_in.dev        = dev_ff;
      div_in.neg_u      = nu[MAG_W-1];
      div_in.neg_l      = nl[MAG_W-1];
      div_in.num_u      = {(nu[MAG_W-1] ? MAG_W'(-nu) : MAG_W'(nu)), 16'h0};
      div_in.num_l      = {(nl[MAG_W-1] ? MAG_W'(-nl) : MAG_W'(nl)), 16'h0};
   end

   div_type div_reg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         div_reg_ff.side.valid <= 1'b0;
      end else if (advance) begin
         div_reg_ff <= div_in;
      end
   end

   ehm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .div_in  (div_reg_ff),
      .div_out (div_out)
   );

   side_type            q_side;
   logic [TABLE_AW-1:0] bin_u, bin_l;

   ehm_quant u_quant (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .bin_scale (bin_scale_ff),
      .value_min (value_min_ff),
      .div_in    (div_out),
      .side_out  (q_side),
      .bin_u     (bin_u),
      .bin_l     (bin_l)
   );

   // Table access: loads write here, in order with the reads of classify beats.
   logic                load_we;
   logic [COUNT_W-1:0]  cnt_u, cnt_l;
   side_type            rd_side_ff;

   assign load_we = advance && q_side.valid && (q_side.cmd == CMD_LOAD);

   ehm_ram #(.WIDTH(COUNT_W), .DEPTH(TABLE_DEPTH)) u_table_u (
      .clock   (clock),
      .wr_en   (load_we),
      .wr_addr (q_side.index),
      .wr_data (q_side.count),
      .rd_en   (advance),
      .rd_addr (bin_u),
      .rd_data (cnt_u)
   );

   ehm_ram #(.WIDTH(COUNT_W), .DEPTH(TABLE_DEPTH)) u_table_l (
      .clock   (clock),
      .wr_en   (load_we),
      .wr_addr (q_side.index),
      .wr_data (q_side.count),
      .rd_en   (advance),
      .rd_addr (bin_l),
      .rd_data (cnt_l)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_side_ff.valid <= 1'b0;
      end else if (advance) begin
         rd_side_ff <= q_side;
      end
   end

   // Output: mask when there is no divide fault and twice the count difference is below the query length.
   always_comb begin
      logic signed [COUNT_W+1:0] d2;
      d2 = ($signed({2'b00, cnt_u}) - $signed({2'b00, cnt_l})) <<< 1;
      mask_in = !rd_side_ff.fault && (d2 < $signed({2'b00, query_length_ff}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         rsp_tvalid_ff <= rd_side_ff.valid && (rd_side_ff.cmd == CMD_CLASSIFY);
      end
      if (advance) begin
         mask_ff  <= mask_in;
         fault_ff <= rd_side_ff.fault;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'b0, fault_ff, mask_ff};

endmodule
